// ===== hw/rtl/crcsfr_pkg.sv =====
package crcsfr_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_START_MARKER  = 3'd0;
	localparam logic [2:0] REG_END_MARKER    = 3'd1;
	localparam logic [2:0] REG_CRC_POLY      = 3'd2;
	localparam logic [2:0] REG_LENGTH_LIMIT  = 3'd3;
	localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd4;

	// Register reset values
	localparam logic [7:0]  RST_START_MARKER  = 8'h00;
	localparam logic [7:0]  RST_END_MARKER    = 8'h00;
	localparam logic [7:0]  RST_CRC_POLY      = 8'h8C;
	localparam logic [7:0]  RST_LENGTH_LIMIT  = 8'hFF;
	localparam logic [31:0] RST_TIMEOUT_TICKS = 32'd1000;

	// CRC seed, also the residue after a restart
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_LEN = 2'd1;
	localparam logic [1:0] ST_END = 2'd2;
	localparam logic [1:0] ST_CRC = 2'd3;

	// Item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic [7:0]  start_marker;
		logic [7:0]  end_marker;
		logic [7:0]  crc_poly;
		logic [7:0]  length_limit;
		logic [31:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] frame_byte;
		logic [1:0] status_code;
		logic [7:0] byte_count;
	} result_t;

	// Reflected CRC-8 update over one byte, LSB first
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/crcsfr_frame.sv =====
module crcsfr_frame
	import crcsfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       item_kind,
	input  logic [7:0] item_byte,
	input  logic       fire,
	output logic       res_valid,
	output result_t    res
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	logic [1:0]  phase_q;
	logic [7:0]  stored_q;
	logic [7:0]  expected_q;
	logic [7:0]  residue_q;
	logic [31:0] elapsed_q;

	logic [1:0]  phase_nxt;
	logic [7:0]  stored_nxt;
	logic [7:0]  expected_nxt;
	logic [7:0]  residue_nxt;
	logic [31:0] elapsed_nxt;
	logic [31:0] elapsed_inc;
	logic [7:0]  crc_new;
	logic [7:0]  stored_inc;
	logic        restart;
	logic [1:0]  res_code;
	logic        emit_data;
	logic        emit_status;

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign crc_new     = crc_fold(residue_q, item_byte, cfg.crc_poly);
	assign stored_inc  = stored_q + 8'd1;

	// Decide what the current item does
	always_comb begin
		emit_data    = 1'b0;
		emit_status  = 1'b0;
		res_code     = ST_OK;
		phase_nxt    = phase_q;
		expected_nxt = expected_q;
		elapsed_nxt  = elapsed_q;
		if (item_kind == KIND_TICK) begin
			elapsed_nxt = elapsed_inc;
			if (elapsed_inc >= cfg.timeout_ticks) begin
				emit_status = 1'b1;
				res_code    = (residue_q != 8'd0) ? ST_CRC : ST_OK;
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (item_byte == cfg.start_marker) begin
						phase_nxt = PH_LEN;
					end
				end
				PH_LEN: begin
					if (item_byte == 8'd0 || item_byte > cfg.length_limit) begin
						emit_status = 1'b1;
						res_code    = ST_LEN;
					end else begin
						expected_nxt = item_byte;
						phase_nxt    = PH_DATA;
						emit_data    = 1'b1;
					end
				end
				default: begin
					if (stored_q >= expected_q) begin
						emit_status = 1'b1;
						if (item_byte != cfg.end_marker) begin
							res_code = ST_END;
						end else begin
							res_code = (residue_q != 8'd0) ? ST_CRC : ST_OK;
						end
					end else begin
						emit_data = 1'b1;
					end
				end
			endcase
		end
		restart     = emit_status;
		stored_nxt  = emit_data ? stored_inc : stored_q;
		residue_nxt = emit_data ? crc_new : residue_q;
		if (restart) begin
			phase_nxt    = PH_HUNT;
			stored_nxt   = 8'd0;
			expected_nxt = 8'd0;
			residue_nxt  = CRC_INIT;
			elapsed_nxt  = 32'd0;
		end
	end

	// Result for the current item
	always_comb begin
		res_valid       = emit_data | emit_status;
		res.is_status   = emit_status;
		res.frame_byte  = emit_data ? item_byte : 8'd0;
		res.status_code = emit_status ? res_code : ST_OK;
		res.byte_count  = emit_data ? stored_inc : stored_q;
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			stored_q   <= 8'd0;
			expected_q <= 8'd0;
			residue_q  <= CRC_INIT;
			elapsed_q  <= 32'd0;
		end else if (fire) begin
			phase_q    <= phase_nxt;
			stored_q   <= stored_nxt;
			expected_q <= expected_nxt;
			residue_q  <= residue_nxt;
			elapsed_q  <= elapsed_nxt;
		end
	end

	// A status item leaves the frame state restarted
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid && res.is_status |=>
			phase_q == PH_HUNT && stored_q == 8'd0 && residue_q == CRC_INIT
			&& elapsed_q == 32'd0)
		else $error("frame state not restarted after status");

	// Stored bytes never run past the frame length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> stored_q <= expected_q && expected_q != 8'd0)
		else $error("stored count past frame length");

	// Outside a frame nothing is stored
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DATA |-> stored_q == 8'd0 && residue_q == CRC_INIT)
		else $error("stale frame state while hunting");

endmodule

// ===== hw/rtl/crc8_serial_frame_receiver.sv =====
// Serial frame receiver with reflected CRC-8 check.
//
// Input channel (in_valid / in_stall): one item per transfer, either a received
// byte (kind = 0, rx_byte) or one timer tick (kind = 1).
// Output channel (out_valid / out_stall): zero or one result per input item,
// either a frame byte (is_status = 0) or an end-of-frame status.
// Config channel (cfg_valid / cfg_ready): register index and data; always
// ready, write only while no item is in flight.
//
// Throughput: one item per cycle while no stall holds it back. An accepted item
// loads the input register, and its result then loads the result register, from
// which it is taken. The CRC byte fold, length and end checks and the 32-bit tick
// compare all sit in the single stage between.
// When out_stall holds a waiting result, the input register keeps its item
// and in_stall rises once it is full; items that give no result still drain.
// Reset returns the block to hunting for the start byte, with registers at
// their default values and both registers empty.
module crc8_serial_frame_receiver
	import crcsfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_status,
	output logic [7:0]  frame_byte,
	output logic [1:0]  status_code,
	output logic [7:0]  byte_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    out_q;
	logic       res_valid;
	result_t    res;
	logic       out_free;
	logic       consume;
	logic       in_take;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker  <= RST_START_MARKER;
			cfg_q.end_marker    <= RST_END_MARKER;
			cfg_q.crc_poly      <= RST_CRC_POLY;
			cfg_q.length_limit  <= RST_LENGTH_LIMIT;
			cfg_q.timeout_ticks <= RST_TIMEOUT_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_MARKER:  cfg_q.start_marker  <= cfg_data[7:0];
				REG_END_MARKER:    cfg_q.end_marker    <= cfg_data[7:0];
				REG_CRC_POLY:      cfg_q.crc_poly      <= cfg_data[7:0];
				REG_LENGTH_LIMIT:  cfg_q.length_limit  <= cfg_data[7:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the staged item moves on unless its result has nowhere to go
	assign out_free = !out_valid_q || !out_stall;
	assign consume  = valid_s1 && (!res_valid || out_free);
	assign in_stall = valid_s1 && !consume;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
		end
	end

	crcsfr_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_kind (kind_s1),
		.item_byte (byte_s1),
		.fire      (consume),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign is_status   = out_q.is_status;
	assign frame_byte  = out_q.frame_byte;
	assign status_code = out_q.status_code;
	assign byte_count  = out_q.byte_count;

	// A result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(consume && res_valid))
		else $error("result overwritten while stalled");

	// Status results carry no byte; data results carry a nonzero count and ok code
	a_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.is_status && out_q.frame_byte == 8'd0)
			|| (!out_q.is_status && out_q.status_code == ST_OK
			&& out_q.byte_count != 8'd0))
		else $error("malformed result");

	// A length error always reports an empty frame
	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_status && out_q.status_code == ST_LEN |->
			out_q.byte_count == 8'd0)
		else $error("length error with nonzero count");

endmodule

// ===== test/tb_crc8_serial_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_crc8_serial_frame_receiver;
	import crcsfr_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} serial_item_t;

	typedef enum logic [1:0] {RX_HUNT, RX_LEN, RX_BODY} rx_phase_e;

	typedef enum int {FR_GOOD, FR_BAD_END, FR_BAD_DATA, FR_BAD_LEN, FR_TIMED_OUT} frame_shape_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = KIND_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_status;
	logic [7:0]  frame_byte;
	logic [1:0]  status_code;
	logic [7:0]  byte_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_START_MARKER;
	logic [31:0] cfg_data = 32'h0;

	// items waiting to go out on the serial side, results the receiver owes us
	serial_item_t serial_items_q[$];
	result_t      results_due[$];

	// predictor state and register copy
	cfg_t       regs_model;
	rx_phase_e  rx_phase;
	logic [7:0] n_stored;
	logic [7:0] frame_len;
	logic [7:0] residue;
	logic [31:0] ticks_seen;

	// stimulus plan for the current register setting
	cfg_t plan;
	int   tick_pct;
	int   n_queued = 0;
	int   n_errors = 0;

	// driver and receiver-side state
	serial_item_t next_item;
	int burst_left = 0;
	int gap_left = 0;
	int stall_pct = 0;
	int mode_left = 0;
	int hold_left = 0;
	int hold_at = 200;
	int items_taken = 0;
	int idle_cycles = 0;

	crc8_serial_frame_receiver DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_status   (is_status),
		.frame_byte  (frame_byte),
		.status_code (status_code),
		.byte_count  (byte_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// reflected CRC-8, LSB first
	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] r;
		r = crc ^ b;
		repeat (8) r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
		return r;
	endfunction

	function automatic void frame_restart();
		rx_phase = RX_HUNT;
		n_stored = 8'h00;
		frame_len = 8'h00;
		residue = CRC_INIT;
		ticks_seen = 32'h0;
	endfunction

	// one serial byte or tick through the deframer, zero or one result
	task automatic deframe_step(input logic k, input logic [7:0] b, output logic has,
		output result_t r);
		logic       fin;
		logic       store;
		logic [1:0] code;
		fin = 1'b0;
		store = 1'b0;
		code = ST_OK;
		r = '0;
		if (k == KIND_TICK) begin
			if (ticks_seen != 32'hFFFF_FFFF) ticks_seen++;
			if (ticks_seen >= regs_model.timeout_ticks) begin
				fin = 1'b1;
				code = (residue != 8'h00) ? ST_CRC : ST_OK;
			end
		end else begin
			case (rx_phase)
			RX_HUNT: begin
				if (b == regs_model.start_marker) rx_phase = RX_LEN;
			end
			RX_LEN: begin
				if (b == 8'h00 || b > regs_model.length_limit) begin
					fin = 1'b1;
					code = ST_LEN;
				end else begin
					frame_len = b;
					rx_phase = RX_BODY;
					store = 1'b1;
				end
			end
			default: begin
				if (n_stored >= frame_len) begin
					fin = 1'b1;
					if (b != regs_model.end_marker) code = ST_END;
					else code = (residue != 8'h00) ? ST_CRC : ST_OK;
				end else begin
					store = 1'b1;
				end
			end
			endcase
		end
		has = fin | store;
		if (store) begin
			residue = crc8_fold(residue, b, regs_model.crc_poly);
			n_stored = n_stored + 8'd1;
			r.is_status = 1'b0;
			r.frame_byte = b;
			r.byte_count = n_stored;
		end else if (fin) begin
			r.is_status = 1'b1;
			r.status_code = code;
			r.byte_count = n_stored;
			frame_restart();
		end
	endtask

	// serial side: bursts of items with random gaps, payload held while stalled
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (serial_items_q.size() > 0) begin
				next_item = serial_items_q.pop_front();
				in_valid <= 1'b1;
				kind <= next_item.kind;
				rx_byte <= next_item.rx_byte;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side: stall pattern in stretches, plus a long hold every few hundred items
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) items_taken++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (items_taken >= hold_at) begin
				hold_at += 300;
				hold_left = 150;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(16, 80);
					case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 60;
					default: stall_pct = 90;
					endcase
				end else begin
					mode_left--;
				end
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// check results, then predict from accepted items and register writes
	always @(posedge clk) begin
		logic    has;
		result_t got;
		result_t want;
		if (!arst_n) begin
			regs_model = {RST_START_MARKER, RST_END_MARKER, RST_CRC_POLY, RST_LENGTH_LIMIT,
				RST_TIMEOUT_TICKS};
			frame_restart();
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: is_status %0d frame_byte %0h status_code %0d byte_count %0d",
						is_status, frame_byte, status_code, byte_count);
					n_errors++;
				end else begin
					want = results_due.pop_front();
					got = {is_status, frame_byte, status_code, byte_count};
					if (got.is_status !== want.is_status) begin
						$error("is_status: expected %0h, got %0h", want.is_status, got.is_status);
						n_errors++;
					end
					if (got.frame_byte !== want.frame_byte) begin
						$error("frame_byte: expected %0h, got %0h", want.frame_byte, got.frame_byte);
						n_errors++;
					end
					if (got.status_code !== want.status_code) begin
						$error("status_code: expected %0h, got %0h", want.status_code,
							got.status_code);
						n_errors++;
					end
					if (got.byte_count !== want.byte_count) begin
						$error("byte_count: expected %0h, got %0h", want.byte_count, got.byte_count);
						n_errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_START_MARKER:  regs_model.start_marker = cfg_data[7:0];
				REG_END_MARKER:    regs_model.end_marker = cfg_data[7:0];
				REG_CRC_POLY:      regs_model.crc_poly = cfg_data[7:0];
				REG_LENGTH_LIMIT:  regs_model.length_limit = cfg_data[7:0];
				REG_TIMEOUT_TICKS: regs_model.timeout_ticks = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				deframe_step(kind, rx_byte, has, want);
				if (has) results_due.push_back(want);
			end
		end
	end

	// watchdog: too long without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic push_item(input logic k, input logic [7:0] b);
		serial_items_q.push_back({k, b});
		n_queued++;
	endtask

	// byte, sometimes preceded by a stray tick
	task automatic push_byte(input logic [7:0] b);
		if ($urandom_range(0, 99) < tick_pct) push_item(KIND_TICK, 8'($urandom));
		push_item(KIND_BYTE, b);
	endtask

	// one frame under the current plan; len_req 0 picks a length
	task automatic push_frame(input frame_shape_e shape, input int len_req);
		logic [7:0] len;
		logic [7:0] crc;
		logic [7:0] b;
		int hi;
		int bad_at;
		push_byte(plan.start_marker);
		if (shape == FR_BAD_LEN) begin
			if (plan.length_limit == 8'hFF || $urandom_range(0, 2) == 0)
				push_byte(8'h00);
			else
				push_byte(8'($urandom_range(int'(plan.length_limit) + 1, 255)));
			return;
		end
		hi = (plan.length_limit < 8'd10) ? int'(plan.length_limit) : 10;
		if (len_req > 0) len = 8'(len_req);
		else if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(1, int'(plan.length_limit)));
		else len = 8'($urandom_range(1, hi));
		bad_at = (shape == FR_BAD_DATA && len >= 8'd2) ? $urandom_range(1, int'(len) - 1) : -1;
		push_byte(len);
		crc = crc8_fold(CRC_INIT, len, plan.crc_poly);
		// for lengths above one, the last stored byte carries the CRC so the residue ends at zero
		for (int i = 1; i < int'(len); i++) begin
			b = (i == int'(len) - 1) ? crc : 8'($urandom);
			crc = crc8_fold(crc, b, plan.crc_poly);
			if (i == bad_at) b = b ^ (8'h01 << $urandom_range(0, 7));
			push_byte(b);
		end
		case (shape)
		FR_BAD_END: push_byte(plan.end_marker ^ 8'($urandom_range(1, 255)));
		FR_TIMED_OUT: begin
			if (plan.timeout_ticks <= 32'd64)
				repeat (int'(plan.timeout_ticks)) push_item(KIND_TICK, 8'($urandom));
			else
				push_byte(plan.end_marker);
		end
		default: push_byte(plan.end_marker);
		endcase
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(REG_START_MARKER, {24'h0, c.start_marker});
		write_reg(REG_END_MARKER, {24'h0, c.end_marker});
		write_reg(REG_CRC_POLY, {24'h0, c.crc_poly});
		write_reg(REG_LENGTH_LIMIT, {24'h0, c.length_limit});
		write_reg(REG_TIMEOUT_TICKS, c.timeout_ticks);
		plan = c;
	endtask

	// sender pauses until every result is in, then lets the pipeline settle
	task automatic wait_idle();
		do @(negedge clk);
		while (serial_items_q.size() != 0 || in_valid || results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly well-formed frames with random content, some broken ones and noise
	task automatic run_random_phase(input cfg_t c, input int tick_rate, input int n_items,
		input int big_len);
		int roll;
		int target;
		load_config(c);
		tick_pct = tick_rate;
		target = n_queued + n_items;
		if (big_len > 0) push_frame(FR_GOOD, big_len);
		while (n_queued < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) repeat ($urandom_range(1, 3)) push_item(KIND_BYTE, 8'($urandom));
			else if (roll < 60) push_frame(FR_GOOD, 0);
			else if (roll < 70) push_frame(FR_BAD_END, 0);
			else if (roll < 80) push_frame(FR_BAD_DATA, 0);
			else if (roll < 88) push_frame(FR_BAD_LEN, 0);
			else push_frame(FR_TIMED_OUT, 0);
		end
		wait_idle();
	endtask

	initial begin
		cfg_t rnd_cfg;
		plan = {RST_START_MARKER, RST_END_MARKER, RST_CRC_POLY, RST_LENGTH_LIMIT,
			RST_TIMEOUT_TICKS};
		tick_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset settings: noise, zero length, one-byte frame with bad CRC,
		// good frame, wrong end byte, ticks
		push_item(KIND_BYTE, 8'h55);
		push_item(KIND_BYTE, 8'hFF);
		push_frame(FR_BAD_LEN, 0);
		push_frame(FR_GOOD, 1);
		push_frame(FR_GOOD, 4);
		push_frame(FR_BAD_END, 2);
		push_item(KIND_TICK, 8'hFF);
		push_item(KIND_TICK, 8'h00);
		wait_idle();

		// directed, tight limits: length above limit, timeout while hunting,
		// timeout with a clean residue before the end byte
		load_config({8'hFF, 8'h00, 8'h8C, 8'd5, 32'd3});
		push_item(KIND_BYTE, 8'hFF);
		push_item(KIND_BYTE, 8'd6);
		repeat (3) push_item(KIND_TICK, 8'h00);
		push_frame(FR_TIMED_OUT, 3);
		wait_idle();

		// random phases across register extremes
		run_random_phase({8'h7E, 8'h7D, 8'h8C, 8'hFF, 32'hFFFF_FFFF}, 3, 60, 255);
		run_random_phase({8'hFF, 8'h00, 8'h07, 8'd12, 32'd1}, 2, 90, 0);
		run_random_phase({8'h00, 8'hFF, 8'hFF, 8'd1, 32'd25}, 10, 90, 0);
		run_random_phase({8'hA5, 8'h5A, 8'h00, 8'd200, 32'd40}, 5, 90, 0);
		repeat (2) begin
			rnd_cfg.start_marker = 8'($urandom);
			rnd_cfg.end_marker = 8'($urandom);
			rnd_cfg.crc_poly = 8'($urandom);
			rnd_cfg.length_limit = 8'($urandom_range(1, 255));
			rnd_cfg.timeout_ticks = 32'($urandom_range(1, 60));
			run_random_phase(rnd_cfg, $urandom_range(0, 8), 90, 0);
		end

		if (results_due.size() != 0) begin
			$error("%0d results never arrived", results_due.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/crcsfr_pkg.sv
hw/rtl/crcsfr_frame.sv
hw/rtl/crc8_serial_frame_receiver.sv
test/tb_crc8_serial_frame_receiver.sv
